>>> design/scs_pkg.sv
`timescale 1ns / 1ps
package scs_pkg;

  localparam int COORD_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // configuration port
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_IDX_W   = CFG_ADDR_W - 3;
  localparam int MIN_LEN_W   = 36;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH_SQ = CFG_IDX_W'(0);

  // hit counts
  localparam logic [1:0] HITS_NONE = 2'd0;
  localparam logic [1:0] HITS_TWO  = 2'd2;

endpackage

>>> design/scs_if.sv
`timescale 1ns / 1ps
interface scs_in_if #(
  parameter int COORD_BITS = scs_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic        [COORD_BITS-1:0] circle_radius;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (
    output valid, center_x, center_y, circle_radius, start_x, start_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, circle_radius, start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

interface scs_out_if #(
  parameter int FRACTION_BITS = scs_pkg::FRACTION_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               hit_count;
  logic [FRACTION_BITS:0]   first_fraction;
  logic [FRACTION_BITS:0]   second_fraction;

  modport source (
    output valid, hit_count, first_fraction, second_fraction,
    input  ready
  );
  modport sink (
    input  valid, hit_count, first_fraction, second_fraction,
    output ready
  );
endinterface

>>> design/scs_sqrt.sv
`timescale 1ns / 1ps
// pipelined integer square root, one result bit per stage
module scs_sqrt #(
  parameter int DW  = 69,
  parameter int SBW = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [DW-1:0]          rad,
  input  logic [SBW-1:0]         in_side,
  output logic                   out_valid,
  output logic [(DW+1)/2-1:0]    root,
  output logic [SBW-1:0]         out_side
);
  localparam int SW  = (DW + 1) / 2;
  localparam int RW  = SW + 2;
  localparam int DPW = 2 * SW;

  logic           vld_r  [SW];
  logic [RW-1:0]  rem_r  [SW];
  logic [SW-1:0]  root_r [SW];
  logic [DPW-1:0] rad_r  [SW];
  logic [SBW-1:0] side_r [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic           v_p;
    logic [RW-1:0]  rem_p;
    logic [SW-1:0]  root_p;
    logic [DPW-1:0] rad_p;
    logic [SBW-1:0] side_p;
    logic [RW-1:0]  remn;
    logic [RW-1:0]  trial;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = DPW'(rad);
      assign side_p = in_side;
    end else begin : g_next
      assign v_p    = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign side_p = side_r[k-1];
    end

    // bring down the next two radicand bits
    always_comb begin
      remn  = {rem_p[RW-3:0], rad_p[DPW-1 -: 2]};
      trial = {root_p, 2'b01};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (remn >= trial) begin
          rem_r[k]  <= remn - trial;
          root_r[k] <= {root_p[SW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= remn;
          root_r[k] <= {root_p[SW-2:0], 1'b0};
        end
        rad_r[k]  <= rad_p << 2;
        side_r[k] <= side_p;
      end
    end
  end

  assign out_valid = vld_r[SW-1];
  assign root      = root_r[SW-1];
  assign out_side  = side_r[SW-1];

endmodule

>>> design/scs_frac.sv
`timescale 1ns / 1ps
// two-lane pipelined restoring divider, n * 2^FB / d for n <= d
module scs_frac #(
  parameter int TW = 34,
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [TW-1:0] num_a,
  input  logic [TW-1:0] num_b,
  input  logic [TW-1:0] den,
  input  logic [1:0]    in_hits,
  output logic          out_valid,
  output logic [FB:0]   quo_a,
  output logic [FB:0]   quo_b,
  output logic [1:0]    out_hits
);
  logic          vld_r  [FB+1];
  logic [TW-1:0] ra_r   [FB+1];
  logic [TW-1:0] rb_r   [FB+1];
  logic [FB:0]   qa_r   [FB+1];
  logic [FB:0]   qb_r   [FB+1];
  logic [TW-1:0] den_r  [FB+1];
  logic [1:0]    hits_r [FB+1];

  // integer part: the numerator never exceeds the divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qa_r[0]   <= (FB+1)'(num_a >= den);
      ra_r[0]   <= (num_a >= den) ? '0 : num_a;
      qb_r[0]   <= (FB+1)'(num_b >= den);
      rb_r[0]   <= (num_b >= den) ? '0 : num_b;
      den_r[0]  <= den;
      hits_r[0] <= in_hits;
    end
  end

  for (genvar k = 1; k <= FB; k++) begin : g_step
    logic [TW:0] sa;
    logic [TW:0] sb;

    always_comb begin
      sa = {ra_r[k-1], 1'b0};
      sb = {rb_r[k-1], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (sa >= {1'b0, den_r[k-1]}) begin
          ra_r[k] <= TW'(sa - {1'b0, den_r[k-1]});
          qa_r[k] <= {qa_r[k-1][FB-1:0], 1'b1};
        end else begin
          ra_r[k] <= TW'(sa);
          qa_r[k] <= {qa_r[k-1][FB-1:0], 1'b0};
        end
        if (sb >= {1'b0, den_r[k-1]}) begin
          rb_r[k] <= TW'(sb - {1'b0, den_r[k-1]});
          qb_r[k] <= {qb_r[k-1][FB-1:0], 1'b1};
        end else begin
          rb_r[k] <= TW'(sb);
          qb_r[k] <= {qb_r[k-1][FB-1:0], 1'b0};
        end
        den_r[k]  <= den_r[k-1];
        hits_r[k] <= hits_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[FB];
  assign quo_a     = qa_r[FB];
  assign quo_b     = qb_r[FB];
  assign out_hits  = hits_r[FB];

endmodule

>>> design/segment_circle_intersection.sv
`timescale 1ns / 1ps
// Segment / circle intersection. Each input beat carries a circle and a segment; each produces
// exactly one result beat with the number of crossings inside the segment (0..2) and their
// positions along it as unsigned Q1.FRACTION_BITS fractions, the (+) root first. The block is a
// single pipeline that takes one beat per clock while the output is not stalled. Front stages
// build the quadratic and its discriminant with split multipliers, the square root resolves one
// bit per stage, and the two divider lanes resolve one quotient bit per stage. A stall at the
// output freezes the whole pipeline. min_length_sq sits at byte address 0 of the APB port and
// should only be written while the pipeline is empty.
module segment_circle_intersection #(
  parameter int COORD_BITS    = scs_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = scs_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  scs_in_if.sink                        in_ch,
  scs_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [scs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [scs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  localparam int CB  = COORD_BITS;
  localparam int FB  = FRACTION_BITS;
  localparam int DXW = CB + 1;
  localparam int PW  = 2 * CB + 2;
  localparam int AW  = 2 * CB + 1;
  localparam int BW  = 2 * CB + 3;
  localparam int CW  = 2 * CB + 2;
  localparam int BMW = 2 * CB + 2;
  localparam int CMW = 2 * CB + 1;
  localparam int LO  = CB + 1;
  localparam int B2W = 2 * BMW;
  localparam int ACW = AW + CMW;
  localparam int DW  = 4 * CB + 5;
  localparam int SW  = (DW + 1) / 2;
  localparam int TW  = 2 * CB + 2;
  localparam int NW  = 2 * CB + 5;
  localparam int MLW = scs_pkg::MIN_LEN_W;
  localparam int LW  = (AW > MLW) ? AW : MLW;
  localparam int SBW = 2 + BW + TW;

  logic adv;

  // ---------------- configuration ----------------
  logic [MLW-1:0] min_len_r;
  logic           cfg_wr;
  logic           cfg_hit;

  assign cfg_hit = (paddr[scs_pkg::CFG_ADDR_W-1:3] == scs_pkg::REG_MIN_LENGTH_SQ);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? scs_pkg::CFG_DATA_W'(min_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= '0;
    end else if (cfg_wr) begin
      min_len_r <= pwdata[MLW-1:0];
    end
  end

  // ---------------- front stages ----------------
  logic [7:1] vld_r;

  // stage 1: differences
  logic signed [DXW-1:0] dx_r, dy_r, ox_r, oy_r;
  logic        [CB-1:0]  rad_r;
  // stage 2: products
  logic signed [PW-1:0]  dxx_r, dyy_r, dxo_r, dyo_r, oxx_r, oyy_r;
  logic        [2*CB-1:0] rr2_r;
  // stage 3: quadratic coefficients
  logic        [AW-1:0]  a3_r;
  logic signed [BW-1:0]  b3_r;
  logic signed [CW-1:0]  c3_r;
  // stage 4: magnitudes
  logic        [AW-1:0]  a4_r;
  logic        [BMW-1:0] bm4_r;
  logic        [CMW-1:0] cm4_r;
  logic                  cneg4_r, long4_r;
  logic signed [BW-1:0]  b4_r;
  logic        [TW-1:0]  ta4_r;
  // stage 5: partial products
  logic [BMW+LO-1:0]          pbl_r;
  logic [2*BMW-LO-1:0]        pbh_r;
  logic [AW+LO-1:0]           pcl_r;
  logic [AW+CMW-LO-1:0]       pch_r;
  logic                       cneg5_r, long5_r;
  logic signed [BW-1:0]       b5_r;
  logic        [TW-1:0]       ta5_r;
  // stage 6: squares
  logic [B2W-1:0]        b2_r;
  logic [B2W-1:0]        ac4_r;
  logic                  cneg6_r, long6_r;
  logic signed [BW-1:0]  b6_r;
  logic        [TW-1:0]  ta6_r;
  // stage 7: discriminant
  logic [DW-1:0]         d7_r;
  logic                  ok7_r, dz7_r;
  logic signed [BW-1:0]  b7_r;
  logic        [TW-1:0]  ta7_r;

  logic signed [DXW-1:0] dx_nxt, dy_nxt, ox_nxt, oy_nxt;
  logic signed [PW-1:0]  bsum;
  logic signed [PW-1:0]  asum;
  logic signed [BW-1:0]  babs;
  logic signed [CW-1:0]  cabs;
  logic [B2W-1:0]        b2_nxt, ac4_nxt;
  logic [ACW-1:0]        ac;
  logic [DW-1:0]         d_nxt;

  always_comb begin
    dx_nxt  = DXW'(in_ch.end_x) - DXW'(in_ch.start_x);
    dy_nxt  = DXW'(in_ch.end_y) - DXW'(in_ch.start_y);
    ox_nxt  = DXW'(in_ch.start_x) - DXW'(in_ch.center_x);
    oy_nxt  = DXW'(in_ch.start_y) - DXW'(in_ch.center_y);
    asum    = dxx_r + dyy_r;
    bsum    = dxo_r + dyo_r;
    babs    = b3_r[BW-1] ? -b3_r : b3_r;
    cabs    = c3_r[CW-1] ? -c3_r : c3_r;
    b2_nxt  = B2W'(pbl_r) + (B2W'(pbh_r) << LO);
    ac      = ACW'(pcl_r) + (ACW'(pch_r) << LO);
    ac4_nxt = {ac, 2'b00};
    d_nxt   = cneg6_r ? DW'(b2_r) + DW'(ac4_r) : DW'(b2_r) - DW'(ac4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[6:1], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      rad_r <= in_ch.circle_radius;

      dxx_r <= dx_r * dx_r;
      dyy_r <= dy_r * dy_r;
      dxo_r <= dx_r * ox_r;
      dyo_r <= dy_r * oy_r;
      oxx_r <= ox_r * ox_r;
      oyy_r <= oy_r * oy_r;
      rr2_r <= rad_r * rad_r;

      a3_r <= asum[AW-1:0];
      b3_r <= {bsum, 1'b0};
      c3_r <= oxx_r + oyy_r - $signed({2'b00, rr2_r});

      a4_r    <= a3_r;
      bm4_r   <= babs[BMW-1:0];
      cm4_r   <= cabs[CMW-1:0];
      cneg4_r <= c3_r[CW-1];
      long4_r <= LW'(a3_r) > LW'(min_len_r);
      b4_r    <= b3_r;
      ta4_r   <= {a3_r, 1'b0};

      // wide products split at LO bits of the multiplier
      pbl_r   <= bm4_r * bm4_r[LO-1:0];
      pbh_r   <= bm4_r * bm4_r[BMW-1:LO];
      pcl_r   <= a4_r * cm4_r[LO-1:0];
      pch_r   <= a4_r * cm4_r[CMW-1:LO];
      cneg5_r <= cneg4_r;
      long5_r <= long4_r;
      b5_r    <= b4_r;
      ta5_r   <= ta4_r;

      b2_r    <= b2_nxt;
      ac4_r   <= ac4_nxt;
      cneg6_r <= cneg5_r;
      long6_r <= long5_r;
      b6_r    <= b5_r;
      ta6_r   <= ta5_r;

      d7_r  <= d_nxt;
      ok7_r <= long6_r && (cneg6_r || (b2_r >= ac4_r));
      dz7_r <= !cneg6_r && (b2_r == ac4_r);
      b7_r  <= b6_r;
      ta7_r <= ta6_r;
    end
  end

  // ---------------- square root ----------------
  logic           sq_valid;
  logic [SW-1:0]  sq_root;
  logic [SBW-1:0] sq_side;

  scs_sqrt #(
    .DW  (DW),
    .SBW (SBW)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (vld_r[7]),
    .rad       (d7_r),
    .in_side   ({ok7_r, dz7_r, b7_r, ta7_r}),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // ---------------- root numerators ----------------
  logic                 sq_ok, sq_dz;
  logic signed [BW-1:0] sq_b;
  logic [TW-1:0]        sq_ta;

  assign {sq_ok, sq_dz, sq_b, sq_ta} = sq_side;

  logic                 p1_vld_r, p2_vld_r;
  logic signed [NW-1:0] n0_r, n1_r;
  logic                 p1_ok_r, p1_dz_r;
  logic [TW-1:0]        p1_ta_r;
  logic [1:0]           p2_hits_r;
  logic [TW-1:0]        p2_na_r, p2_nb_r, p2_ta_r;

  logic signed [NW-1:0] nb_neg, ns;
  logic signed [NW-1:0] ta_s;
  logic                 keep0, keep1;

  always_comb begin
    nb_neg = -NW'(sq_b);
    ns     = $signed(NW'(sq_root));
    ta_s   = $signed(NW'(p1_ta_r));
    keep0  = p1_ok_r && !n0_r[NW-1] && (n0_r <= ta_s);
    keep1  = p1_ok_r && !p1_dz_r && !n1_r[NW-1] && (n1_r <= ta_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= sq_valid;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n0_r    <= nb_neg + ns;
      n1_r    <= nb_neg - ns;
      p1_ok_r <= sq_ok;
      p1_dz_r <= sq_dz;
      p1_ta_r <= sq_ta;

      p2_hits_r <= {1'b0, keep0} + {1'b0, keep1};
      p2_na_r   <= keep0 ? n0_r[TW-1:0] : n1_r[TW-1:0];
      p2_nb_r   <= n1_r[TW-1:0];
      p2_ta_r   <= p1_ta_r;
    end
  end

  // ---------------- fractions ----------------
  logic        dv_valid;
  logic [FB:0] dv_qa, dv_qb;
  logic [1:0]  dv_hits;

  scs_frac #(
    .TW (TW),
    .FB (FB)
  ) u_frac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (p2_vld_r),
    .num_a     (p2_na_r),
    .num_b     (p2_nb_r),
    .den       (p2_ta_r),
    .in_hits   (p2_hits_r),
    .out_valid (dv_valid),
    .quo_a     (dv_qa),
    .quo_b     (dv_qb),
    .out_hits  (dv_hits)
  );

  // last divider stage is the output register
  assign adv                    = !dv_valid || out_ch.ready;
  assign in_ch.ready            = adv;
  assign out_ch.valid           = dv_valid;
  assign out_ch.hit_count       = dv_hits;
  assign out_ch.first_fraction  = (dv_hits != scs_pkg::HITS_NONE) ? dv_qa : '0;
  assign out_ch.second_fraction = (dv_hits == scs_pkg::HITS_TWO) ? dv_qb : '0;

`ifndef SYNTH
  a_hits_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.hit_count != 2'd3)
    else $error("hit count out of range");

  a_root_order : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit_count == scs_pkg::HITS_TWO |->
      out_ch.first_fraction >= out_ch.second_fraction)
    else $error("plus root does not come first");

  a_frac_limit : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit_count != scs_pkg::HITS_NONE |->
      out_ch.first_fraction <= (FB+1)'(1) << FB)
    else $error("fraction above one");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(p2_vld_r))
    else $error("pipeline moved during stall");
`endif

endmodule

>>> bench/tb_segment_circle_intersection.sv
`timescale 1ns / 1ps
module tb_segment_circle_intersection;

  localparam int CB = scs_pkg::COORD_BITS_DEF;
  localparam int FB = scs_pkg::FRACTION_BITS_DEF;
  localparam int LATENCY = 7 + (2 * CB + 3) + 2 + (FB + 1);
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
    logic [CB-1:0] rad;
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic signed [CB-1:0] ex;
    logic signed [CB-1:0] ey;
  } geom_t;

  typedef struct packed {
    logic [1:0] hits;
    logic [FB:0] f0;
    logic [FB:0] f1;
  } crossing_t;

  class crossing_board;
    crossing_t pending[$];
    logic [scs_pkg::MIN_LEN_W-1:0] min_len;
    int errors;

    function new();
      min_len = '0;
      errors = 0;
    endfunction

    function logic [63:0] root_floor(logic [127:0] v);
      logic [63:0] res;
      logic [63:0] cand;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = res | (64'd1 << b);
        if (128'(cand) * 128'(cand) <= v) res = cand;
      end
      return res;
    endfunction

    function logic [FB:0] frac_of(logic [63:0] n, logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = (n >= d) ? 64'd1 : 64'd0;
      r = (n >= d) ? 64'd0 : n;
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q[0] = 1'b1;
        end
      end
      return q[FB:0];
    endfunction

    function void note_geom(geom_t g);
      longint dx, dy, ox, oy, qa, qb, qc, two_a, root;
      logic signed [129:0] disc;
      longint nums[2];
      int ncand;
      crossing_t res;
      dx = longint'(g.ex) - longint'(g.sx);
      dy = longint'(g.ey) - longint'(g.sy);
      ox = longint'(g.sx) - longint'(g.cx);
      oy = longint'(g.sy) - longint'(g.cy);
      qa = dx * dx + dy * dy;
      qb = 2 * (dx * ox + dy * oy);
      qc = ox * ox + oy * oy - longint'({1'b0, g.rad}) * longint'({1'b0, g.rad});
      two_a = 2 * qa;
      res = '0;
      ncand = 0;
      if (qa > longint'({28'd0, min_len})) begin
        disc = 130'(signed'(qb)) * 130'(signed'(qb))
             - 130'(signed'(4 * qa)) * 130'(signed'(qc));
        if (disc == 0) begin
          nums[0] = -qb;
          ncand = 1;
        end else if (disc > 0) begin
          root = longint'(root_floor(disc[127:0]));
          nums[0] = -qb + root;
          nums[1] = -qb - root;
          ncand = 2;
        end
        for (int k = 0; k < ncand; k++) begin
          if (nums[k] >= 0 && nums[k] <= two_a) begin
            if (res.hits == 0) res.f0 = frac_of(nums[k], two_a);
            else res.f1 = frac_of(nums[k], two_a);
            res.hits = res.hits + 2'd1;
          end
        end
      end
      pending = {pending, res};
    endfunction

    function void check_result(crossing_t got);
      crossing_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat hits=%0d", got.hits);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hits !== want.hits) begin
        $error("hit_count expected %0d actual %0d", want.hits, got.hits);
        errors++;
      end
      if (got.f0 !== want.f0) begin
        $error("first_fraction expected %0d actual %0d", want.f0, got.f0);
        errors++;
      end
      if (got.f1 !== want.f1) begin
        $error("second_fraction expected %0d actual %0d", want.f1, got.f1);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [scs_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [scs_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [scs_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  scs_in_if #(.COORD_BITS(CB)) in_ch ();
  scs_out_if #(.FRACTION_BITS(FB)) out_ch ();

  segment_circle_intersection #(.COORD_BITS(CB), .FRACTION_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  crossing_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_active = 1'b0;
  longint cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.circle_radius = '0;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.end_x = '0;
    in_ch.end_y = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_segment_circle_intersection: done, errors");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.hit_count, out_ch.first_fraction, out_ch.second_fraction});
    if (hold_active) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off, counted in its own process
  task automatic hold_for(int n);
    hold_active <= 1'b1;
    repeat (n) @(posedge clk);
    hold_active <= 1'b0;
  endtask

  task automatic cfg_write(logic [scs_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == scs_pkg::REG_MIN_LENGTH_SQ) board.min_len = val[scs_pkg::MIN_LEN_W-1:0];
  endtask

  task automatic send_geom(geom_t g);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.center_x, in_ch.center_y, in_ch.circle_radius, in_ch.start_x, in_ch.start_y,
     in_ch.end_x, in_ch.end_y} <= g;
    do @(posedge clk); while (!in_ch.ready);
    board.note_geom(g);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic geom_t rand_geom();
    geom_t g;
    int span;
    span = (1 << $urandom_range(15, 1)) - 1;
    case ($urandom_range(5))
      0: g = geom_t'({$urandom, $urandom, $urandom, $urandom});
      default: begin
        // crossing-prone: segment around the circle, radius comparable to the extent
        g.cx = CB'($urandom_range(2 * span) - span);
        g.cy = CB'($urandom_range(2 * span) - span);
        g.rad = CB'($urandom_range(span));
        g.sx = CB'($urandom_range(2 * span) - span);
        g.sy = CB'($urandom_range(2 * span) - span);
        g.ex = CB'($urandom_range(2 * span) - span);
        g.ey = CB'($urandom_range(2 * span) - span);
      end
    endcase
    return g;
  endfunction

  localparam logic signed [CB-1:0] SMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] SMIN = {1'b1, {(CB-1){1'b0}}};

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tangent, miss, two hits, one hit, zero-length, extremes
    send_geom('{0, 0, 10, -20, 10, 20, 10});
    send_geom('{0, 0, 5, -20, 10, 20, 10});
    send_geom('{0, 0, 10, -20, 0, 20, 0});
    send_geom('{0, 0, 10, 0, 0, 20, 0});
    send_geom('{0, 0, 10, 20, 0, 0, 0});
    send_geom('{0, 0, 10, 3, 3, 3, 3});
    send_geom('{0, 0, 0, 0, 0, 0, 0});
    send_geom('{0, 0, 10, 10, 0, 30, 0});
    send_geom('{0, 0, 10, -10, 0, 10, 0});
    send_geom('{0, 0, 10, 30, 0, 40, 0});
    send_geom('{SMIN, SMIN, 16'hFFFF, SMAX, SMAX, SMIN, SMIN});
    send_geom('{SMAX, SMAX, 16'hFFFF, SMIN, SMIN, SMAX, SMAX});
    send_geom('{SMIN, SMAX, 16'hFFFF, SMIN, SMAX, SMAX, SMIN});
    send_geom('{SMAX, SMIN, 0, SMIN, SMIN, SMAX, SMAX});
    send_geom('{0, 0, 16'hFFFF, SMIN, 0, SMAX, 0});
    send_geom('{16'sd1, -16'sd1, 16'h8000, -16'sd1, 16'sd1, 16'sd2, -16'sd2});
    drain();

    cfg_write(scs_pkg::REG_MIN_LENGTH_SQ, 64'd1600);
    send_geom('{0, 0, 10, -20, 0, 20, 0});
    send_geom('{0, 0, 10, -20, 0, 21, 0});
    send_geom('{0, 0, 10, -20, 0, 20, 1});
    drain();
    cfg_write(scs_pkg::REG_MIN_LENGTH_SQ, 64'h8_0000_0000);
    send_geom('{SMIN, SMIN, 16'hFFFF, SMAX, SMAX, SMIN, SMIN});
    send_geom('{0, 0, 10, -20, 0, 20, 0});
    drain();
    cfg_write(scs_pkg::REG_MIN_LENGTH_SQ, 64'hFFFF_FFF0_0000_0000);
    send_geom('{0, 0, 10, -20, 0, 20, 0});
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        3: begin send_idle_pct = 29; recv_stall_pct = 29; end
        4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      cfg_write(scs_pkg::REG_MIN_LENGTH_SQ,
                (ph == 4) ? 64'h8_0000_0000 : 64'($urandom_range(ph * 40)));
      if (ph == 4) begin
        fork
          hold_for(300);
        join_none
      end
      for (int n = 0; n < 90; n++) begin
        if (ph == 0 && n == 45) drain();
        send_geom(rand_geom());
      end
      drain();
    end

    if (board.errors == 0)
      $display("tb_segment_circle_intersection: done, clean");
    else
      $display("tb_segment_circle_intersection: done, errors");
    $finish;
  end
endmodule

>>> segment_circle_intersection.f
design/scs_pkg.sv
design/scs_if.sv
design/scs_sqrt.sv
design/scs_frac.sv
design/segment_circle_intersection.sv
bench/tb_segment_circle_intersection.sv
